>>> hw/rtl/ouql_pkg.sv
package ouql_pkg;

   localparam int ENTRY_W      = 32;
   localparam int COUNT_OUT_W  = 7;
   localparam int OPCODE_W     = 2;
   localparam int CAPACITY_DEF = 64;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_POP    = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_LOAD,
      CMD_FROM_PREV,
      CMD_FROM_NEXT
   } cell_cmd_type;

   typedef struct packed {
      logic hit;
      logic eq;
   } cell_flags_type;

endpackage

>>> hw/rtl/ouql_req_if.sv
interface ouql_req_if;
   logic                                valid;
   logic                                ready;
   logic [ouql_pkg::OPCODE_W-1:0]       opcode;
   logic signed [ouql_pkg::ENTRY_W-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink (input valid, input opcode, input value, output ready);
endinterface

>>> hw/rtl/ouql_rsp_if.sv
interface ouql_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ouql_pkg::ENTRY_W-1:0]  pop_value;
   logic                                 was_empty;
   logic                                 accepted;
   logic                                 dropped_full;
   logic [ouql_pkg::COUNT_OUT_W-1:0]     entry_count;

   modport source (output valid, output pop_value, output was_empty, output accepted,
                   output dropped_full, output entry_count, input ready);
   modport sink (input valid, input pop_value, input was_empty, input accepted,
                 input dropped_full, input entry_count, output ready);
endinterface

>>> hw/rtl/ouql_csr_if.sv
interface ouql_csr_if;
   logic                                valid;
   logic                                ready;
   logic signed [ouql_pkg::ENTRY_W-1:0] empty_code;

   modport source (output valid, output empty_code, input ready);
   modport sink (input valid, input empty_code, output ready);
endinterface

>>> hw/rtl/ouql_cell.sv
module ouql_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  ouql_pkg::cell_cmd_type              cmd,
   input  logic signed [ouql_pkg::ENTRY_W-1:0] key,
   input  logic signed [ouql_pkg::ENTRY_W-1:0] prev_entry,
   input  logic                                prev_occ,
   input  logic signed [ouql_pkg::ENTRY_W-1:0] next_entry,
   input  logic                                next_occ,
   output logic signed [ouql_pkg::ENTRY_W-1:0] entry,
   output logic                                occ,
   output ouql_pkg::cell_flags_type            flags
);

   logic signed [ouql_pkg::ENTRY_W-1:0] entry_ff, entry_in;
   logic                                occ_ff, occ_in;

   always_comb begin
      entry_in = entry_ff;
      occ_in   = occ_ff;
      case (cmd)
         ouql_pkg::CMD_HOLD: begin
            entry_in = entry_ff;
            occ_in   = occ_ff;
         end
         ouql_pkg::CMD_LOAD: begin
            entry_in = key;
            occ_in   = 1'b1;
         end
         ouql_pkg::CMD_FROM_PREV: begin
            entry_in = prev_entry;
            occ_in   = prev_occ;
         end
         ouql_pkg::CMD_FROM_NEXT: begin
            entry_in = next_entry;
            occ_in   = next_occ;
         end
         default: begin
            entry_in = entry_ff;
            occ_in   = occ_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign entry     = entry_ff;
   assign occ       = occ_ff;
   assign flags.hit = !occ_ff || (key >= entry_ff);
   assign flags.eq  = occ_ff && (key == entry_ff);

endmodule

>>> hw/rtl/ordered_unique_list_queue.sv
// A request is captured in S_IDLE, S_CMP registers the cell compare flags, and
// S_APPLY does the position search (a CAPACITY-bit add) and the row shift and
// registers the response, waiting while an earlier response is not yet taken.
// A new request is taken only after S_APPLY; the request side is ready again
// while a response still waits to be taken. Reset (synchronous): list empties,
// count and empty code go to 0; entry words keep their contents until written.
module ordered_unique_list_queue #(
   parameter int CAPACITY = ouql_pkg::CAPACITY_DEF
) (
   input logic     clock,
   input logic     reset,
   ouql_req_if.sink   req_ch,
   ouql_rsp_if.source rsp_ch,
   ouql_csr_if.sink   csr_ch
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_APPLY
   } state_type;

   state_type                           state_ff;
   ouql_pkg::opcode_type                op_ff;
   logic signed [ouql_pkg::ENTRY_W-1:0] value_ff;
   logic signed [ouql_pkg::ENTRY_W-1:0] empty_code_ff;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [CAPACITY-1:0]                 hit_ff, eq_ff;

   logic signed [ouql_pkg::ENTRY_W-1:0] rsp_pop_value_ff, rsp_pop_value_in;
   logic rsp_valid_ff, rsp_was_empty_ff, rsp_was_empty_in;
   logic rsp_accepted_ff, rsp_accepted_in, rsp_dropped_ff, rsp_dropped_in;

   logic signed [ouql_pkg::ENTRY_W-1:0] cell_entry [CAPACITY];
   logic [CAPACITY-1:0]                 occ_vec, hit_vec, eq_vec;
   ouql_pkg::cell_flags_type            cell_flags [CAPACITY];
   ouql_pkg::cell_cmd_type              cell_cmd [CAPACITY];

   logic [CAPACITY-1:0] sel_vec, first_vec, above_vec;
   logic full, is_put, dup, do_ins, do_pop, go;

   assign go = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_ch.ready);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   // position search: lowest set bit of the selection vector
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign is_put    = (op_ff == ouql_pkg::OP_APPEND) || (op_ff == ouql_pkg::OP_INSERT);
   assign sel_vec   = (op_ff == ouql_pkg::OP_INSERT) ? hit_ff : ~occ_vec;
   assign first_vec = sel_vec & (~sel_vec + CAPACITY'(1));
   assign above_vec = ~(first_vec | (first_vec - CAPACITY'(1)));
   assign dup       = (op_ff == ouql_pkg::OP_INSERT) && |(first_vec & eq_ff);
   assign do_ins    = go && is_put && !dup && !full;
   assign do_pop    = go && (op_ff == ouql_pkg::OP_POP) && (count_ff != '0);

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [ouql_pkg::ENTRY_W-1:0] prev_e, next_e;
         logic                                prev_o, next_o;

         if (gi == 0) begin : g_head
            assign prev_e = '0;
            assign prev_o = 1'b0;
         end else begin : g_mid
            assign prev_e = cell_entry[gi-1];
            assign prev_o = occ_vec[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_tail
            assign next_e = '0;
            assign next_o = 1'b0;
         end else begin : g_body
            assign next_e = cell_entry[gi+1];
            assign next_o = occ_vec[gi+1];
         end

         always_comb begin
            if (do_ins && first_vec[gi]) begin
               cell_cmd[gi] = ouql_pkg::CMD_LOAD;
            end else if (do_ins && above_vec[gi]) begin
               cell_cmd[gi] = ouql_pkg::CMD_FROM_PREV;
            end else if (do_pop) begin
               cell_cmd[gi] = ouql_pkg::CMD_FROM_NEXT;
            end else begin
               cell_cmd[gi] = ouql_pkg::CMD_HOLD;
            end
         end

         ouql_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cell_cmd[gi]),
            .key        (value_ff),
            .prev_entry (prev_e),
            .prev_occ   (prev_o),
            .next_entry (next_e),
            .next_occ   (next_o),
            .entry      (cell_entry[gi]),
            .occ        (occ_vec[gi]),
            .flags      (cell_flags[gi])
         );

         assign hit_vec[gi] = cell_flags[gi].hit;
         assign eq_vec[gi]  = cell_flags[gi].eq;
      end
   endgenerate

   always_comb begin
      count_in         = count_ff;
      rsp_pop_value_in = '0;
      rsp_was_empty_in = 1'b0;
      rsp_accepted_in  = do_ins;
      rsp_dropped_in   = is_put && !dup && full;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (op_ff == ouql_pkg::OP_POP) begin
         if (count_ff == '0) begin
            rsp_pop_value_in = empty_code_ff;
            rsp_was_empty_in = 1'b1;
         end else begin
            rsp_pop_value_in = cell_entry[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         empty_code_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            empty_code_ff <= csr_ch.empty_code;
         end
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  op_ff    <= ouql_pkg::opcode_type'(req_ch.opcode);
                  value_ff <= req_ch.value;
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               hit_ff   <= hit_vec;
               eq_ff    <= eq_vec;
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               if (go) begin
                  count_ff         <= count_in;
                  rsp_pop_value_ff <= rsp_pop_value_in;
                  rsp_was_empty_ff <= rsp_was_empty_in;
                  rsp_accepted_ff  <= rsp_accepted_in;
                  rsp_dropped_ff   <= rsp_dropped_in;
                  state_ff         <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.pop_value    = rsp_pop_value_ff;
   assign rsp_ch.was_empty    = rsp_was_empty_ff;
   assign rsp_ch.accepted     = rsp_accepted_ff;
   assign rsp_ch.dropped_full = rsp_dropped_ff;
   assign rsp_ch.entry_count  = ouql_pkg::COUNT_OUT_W'(count_ff);

   a_occ_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(occ_vec) == 32'(count_ff))
      else $error("occupied cells differ from count");

   a_occ_contiguous: assert property (@(posedge clock) disable iff (reset)
      (occ_vec & (occ_vec + CAPACITY'(1))) == '0)
      else $error("occupied cells not packed at head");

   a_single_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) && is_put && !full |-> $onehot(first_vec))
      else $error("no single insertion slot");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_accepted_ff && rsp_dropped_ff)
                       && !(rsp_was_empty_ff && rsp_accepted_ff))
      else $error("conflicting response flags");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      go && do_ins |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("count did not advance on insert");

endmodule

>>> bench/tb_top.sv
module tb_top;

   localparam int LIST_CAPACITY    = ouql_pkg::CAPACITY_DEF;
   localparam int RESPONSE_LATENCY = 2;
   localparam int WATCHDOG_CYCLES  = 5000;
   localparam logic signed [ouql_pkg::ENTRY_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [ouql_pkg::ENTRY_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic signed [ouql_pkg::ENTRY_W-1:0] pop_value;
      logic                                was_empty;
      logic                                accepted;
      logic                                dropped_full;
      logic [ouql_pkg::COUNT_OUT_W-1:0]    entry_count;
   } list_reply_type;

   logic clock;
   logic reset;

   ouql_req_if req_ch ();
   ouql_rsp_if rsp_ch ();
   ouql_csr_if csr_ch ();

   ordered_unique_list_queue #(
      .CAPACITY (LIST_CAPACITY)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   logic signed [ouql_pkg::ENTRY_W-1:0] held_list[$];
   logic signed [ouql_pkg::ENTRY_W-1:0] empty_code_model;
   list_reply_type                      expected_replies[$];

   int error_count   = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_request  = 0;
   int quiet_cycles  = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic list_reply_type apply_request(ouql_pkg::opcode_type op,
                                                    logic signed [ouql_pkg::ENTRY_W-1:0] word);
      list_reply_type reply;
      int             pos;
      int             i;
      bit             dup;
      bit             found;
      reply = '0;
      case (op)
         ouql_pkg::OP_APPEND: begin
            if (held_list.size() >= LIST_CAPACITY) begin
               reply.dropped_full = 1'b1;
            end else begin
               held_list.push_back(word);
               reply.accepted = 1'b1;
            end
         end
         ouql_pkg::OP_INSERT: begin
            pos   = held_list.size();
            dup   = 1'b0;
            found = 1'b0;
            i     = 0;
            while (i < held_list.size() && !found) begin
               if (word == held_list[i]) begin
                  dup   = 1'b1;
                  found = 1'b1;
               end else if (word > held_list[i]) begin
                  pos   = i;
                  found = 1'b1;
               end
               i++;
            end
            if (!dup) begin
               if (held_list.size() >= LIST_CAPACITY) begin
                  reply.dropped_full = 1'b1;
               end else begin
                  held_list.insert(pos, word);
                  reply.accepted = 1'b1;
               end
            end
         end
         ouql_pkg::OP_POP: begin
            if (held_list.size() == 0) begin
               reply.pop_value = empty_code_model;
               reply.was_empty = 1'b1;
            end else begin
               reply.pop_value = held_list.pop_front();
            end
         end
         default: begin
         end
      endcase
      reply.entry_count = ouql_pkg::COUNT_OUT_W'(held_list.size());
      return reply;
   endfunction

   task automatic report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_reply();
      list_reply_type want;
      if (expected_replies.size() == 0) begin
         report_mismatch("response transaction with nothing expected");
      end else begin
         want = expected_replies.pop_front();
         if (rsp_ch.pop_value !== want.pop_value)
            report_mismatch($sformatf("pop_value %0d, want %0d",
                                      rsp_ch.pop_value, want.pop_value));
         if (rsp_ch.was_empty !== want.was_empty)
            report_mismatch($sformatf("was_empty %b, want %b",
                                      rsp_ch.was_empty, want.was_empty));
         if (rsp_ch.accepted !== want.accepted)
            report_mismatch($sformatf("accepted %b, want %b",
                                      rsp_ch.accepted, want.accepted));
         if (rsp_ch.dropped_full !== want.dropped_full)
            report_mismatch($sformatf("dropped_full %b, want %b",
                                      rsp_ch.dropped_full, want.dropped_full));
         if (rsp_ch.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, want %0d",
                                      rsp_ch.entry_count, want.entry_count));
      end
   endtask

   // response side: check, then pick ready for the next edge
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            check_reply();
         end
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
             (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("TIMEOUT: no transaction for %0d cycles", WATCHDOG_CYCLES);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic send_request(ouql_pkg::opcode_type op,
                               logic signed [ouql_pkg::ENTRY_W-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      req_ch.value  <= word;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      expected_replies.push_back(apply_request(op, word));
   endtask

   task automatic write_empty_code(logic signed [ouql_pkg::ENTRY_W-1:0] code);
      csr_ch.valid      <= 1'b1;
      csr_ch.empty_code <= code;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) @(posedge clock);
      empty_code_model = code;
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_until_idle();
      req_ch.valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (RESPONSE_LATENCY + 2) @(posedge clock);
   endtask

   function automatic ouql_pkg::opcode_type pick_opcode(int fill_pct);
      if ($urandom_range(99) < 3) return ouql_pkg::OP_NONE;
      if ($urandom_range(99) < fill_pct) begin
         if ($urandom_range(99) < 70) return ouql_pkg::OP_INSERT;
         return ouql_pkg::OP_APPEND;
      end
      return ouql_pkg::OP_POP;
   endfunction

   function automatic logic signed [ouql_pkg::ENTRY_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return WORD_MIN;
         1:       return WORD_MAX;
         2, 3:    return ouql_pkg::ENTRY_W'($urandom_range(16)) - ouql_pkg::ENTRY_W'(8);
         4: begin
            if (held_list.size() > 0) return held_list[$urandom_range(held_list.size() - 1)];
            return '0;
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic test_empty_pop();
      empty_code_model = '0;
      send_request(ouql_pkg::OP_POP, '1);
      send_request(ouql_pkg::OP_NONE, '1);
      wait_until_idle();
      write_empty_code(WORD_MIN);
      send_request(ouql_pkg::OP_POP, '0);
      send_request(ouql_pkg::OP_NONE, '0);
   endtask

   task automatic test_ordered_insert();
      wait_until_idle();
      send_request(ouql_pkg::OP_INSERT, 0);
      send_request(ouql_pkg::OP_INSERT, 0);
      send_request(ouql_pkg::OP_INSERT, WORD_MAX);
      send_request(ouql_pkg::OP_INSERT, WORD_MIN);
      send_request(ouql_pkg::OP_INSERT, -1);
      send_request(ouql_pkg::OP_INSERT, WORD_MAX);
      // leave the list unsorted, then insert ahead of the stray tail entry
      send_request(ouql_pkg::OP_APPEND, 5);
      send_request(ouql_pkg::OP_INSERT, 5);
      send_request(ouql_pkg::OP_INSERT, 3);
      send_request(ouql_pkg::OP_APPEND, WORD_MAX);
      send_request(ouql_pkg::OP_NONE, 32'sh5555_5555);
      repeat (9) send_request(ouql_pkg::OP_POP, 32'shAAAA_AAAA);
   endtask

   task automatic test_full_list();
      wait_until_idle();
      write_empty_code(WORD_MAX);
      while (held_list.size() < LIST_CAPACITY) send_request(ouql_pkg::OP_INSERT, $urandom);
      send_request(ouql_pkg::OP_APPEND, $urandom);
      send_request(ouql_pkg::OP_INSERT, WORD_MAX);
      send_request(ouql_pkg::OP_INSERT, held_list[0]);
      send_request(ouql_pkg::OP_INSERT, held_list[LIST_CAPACITY - 1]);
      send_request(ouql_pkg::OP_NONE, $urandom);
      repeat (LIST_CAPACITY + 1) send_request(ouql_pkg::OP_POP, $urandom);
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_pct,
                                      logic signed [ouql_pkg::ENTRY_W-1:0] code,
                                      int item_total);
      int k;
      int fill_pct;
      wait_until_idle();
      write_empty_code(code);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      fill_pct      = 50;
      for (k = 0; k < item_total; k++) begin
         if (k % 60 == 0) begin
            case ($urandom_range(2))
               0:       fill_pct = 95;
               1:       fill_pct = 55;
               default: fill_pct = 20;
            endcase
         end
         send_request(pick_opcode(fill_pct), pick_value());
      end
   endtask

   task automatic test_backpressure();
      wait_until_idle();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request  = 400;
      repeat (40) send_request(pick_opcode(80), pick_value());
   endtask

   initial begin
      req_ch.valid      <= 1'b0;
      req_ch.opcode     <= ouql_pkg::OP_NONE;
      req_ch.value      <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.empty_code <= '0;
      reset             <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_empty_pop();
      test_ordered_insert();
      test_full_list();
      test_random_traffic(0, 0, '0, 250);
      test_random_traffic(67, 0, -1, 250);
      test_random_traffic(0, 67, $urandom, 250);
      test_random_traffic(12, 12, WORD_MIN + 1, 250);
      test_backpressure();
      wait_until_idle();
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
